>>> design/assert_macros.svh
// Assertion helpers, included by the core that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/tsq_pkg.sv
package tsq_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    STAT_PUSHED = 2'd0,
    STAT_POPPED = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_XFER
  } state_t;

  // One write port and one read port of a stack memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> design/tsq_ram.sv
module tsq_ram #(
  parameter int WIDTH     = 32,
  parameter int ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/tsq_ctrl.sv
module tsq_ctrl import tsq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [DATA_W-1:0]      s_tdata,
  input  logic [0:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [1:0]             m_tuser,
  output mem_req_t               in_req,
  input  logic [DATA_W-1:0]      in_rdata,
  output mem_req_t               out_req,
  input  logic [DATA_W-1:0]      out_rdata
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  in_cnt, in_cnt_next;
  logic [CNT_W-1:0]  out_cnt, out_cnt_next;
  logic [CNT_W-1:0]  xfer_rd, xfer_rd_next;
  logic [CNT_W-1:0]  xfer_wr, xfer_wr_next;
  logic              rd_pend, rd_pend_next;
  logic              flag, flag_next;
  logic [DATA_W-1:0] exp_val, exp_next;

  logic              out_valid;
  status_t           out_status;
  logic [DATA_W-1:0] out_popped;
  logic              out_miss;
  logic              out_all;

  logic              res_load;
  status_t           res_status;
  logic [DATA_W-1:0] res_popped;
  logic              res_miss;

  logic              accept;
  logic              full;
  logic              xfer_last;
  logic [CNT_W-1:0]  in_top;

  assign s_tready  = (state == ST_IDLE) && (!out_valid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign full      = ({1'b0, in_cnt} + {1'b0, out_cnt}) >= SUM_W'(DEPTH);
  assign in_top    = in_cnt - CNT_W'(1);
  assign xfer_last = rd_pend && (xfer_wr == in_top);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && s_tuser[0] == MODE_POP) begin
          if (out_cnt != '0) begin
            state_next = ST_POP;
          end else if (in_cnt != '0) begin
            state_next = ST_XFER;
          end
        end
      end
      ST_POP: begin
        state_next = ST_IDLE;
      end
      ST_XFER: begin
        if (xfer_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory requests, counters and the result of the current item.
  always_comb begin
    in_req       = '0;
    out_req      = '0;
    in_cnt_next  = in_cnt;
    out_cnt_next = out_cnt;
    xfer_rd_next = xfer_rd;
    xfer_wr_next = xfer_wr;
    rd_pend_next = 1'b0;
    exp_next     = exp_val;
    res_load     = 1'b0;
    res_status   = STAT_PUSHED;
    res_popped   = '0;
    res_miss     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser[0] == MODE_PUSH) begin
            res_load = 1'b1;
            if (full) begin
              res_status = STAT_FULL;
            end else begin
              in_req.we    = 1'b1;
              in_req.waddr = in_cnt[ADDR_W-1:0];
              in_req.wdata = s_tdata;
              in_cnt_next  = in_cnt + CNT_W'(1);
            end
          end else begin
            exp_next = s_tdata;
            if (out_cnt != '0) begin
              out_req.re    = 1'b1;
              out_req.raddr = out_cnt[ADDR_W-1:0] - ADDR_W'(1);
              out_cnt_next  = out_cnt - CNT_W'(1);
            end else if (in_cnt != '0) begin
              xfer_rd_next = '0;
              xfer_wr_next = '0;
            end else begin
              res_load   = 1'b1;
              res_status = STAT_EMPTY;
              res_popped = EMPTY_VALUE;
              res_miss   = (s_tdata != EMPTY_VALUE);
            end
          end
        end
      end
      ST_POP: begin
        res_load   = 1'b1;
        res_status = STAT_POPPED;
        res_popped = out_rdata;
        res_miss   = (out_rdata != exp_val);
      end
      ST_XFER: begin
        // Reads walk the input stack from its top; each write follows once its read data is registered.
        if (xfer_rd != in_cnt) begin
          in_req.re    = 1'b1;
          in_req.raddr = in_top[ADDR_W-1:0] - xfer_rd[ADDR_W-1:0];
          xfer_rd_next = xfer_rd + CNT_W'(1);
          rd_pend_next = 1'b1;
        end
        if (xfer_last) begin
          // The oldest element is the one popped, so it is not stored.
          res_load     = 1'b1;
          res_status   = STAT_POPPED;
          res_popped   = in_rdata;
          res_miss     = (in_rdata != exp_val);
          out_cnt_next = in_top;
          in_cnt_next  = '0;
        end else if (rd_pend) begin
          out_req.we    = 1'b1;
          out_req.waddr = xfer_wr[ADDR_W-1:0];
          out_req.wdata = in_rdata;
          xfer_wr_next  = xfer_wr + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    flag_next = flag && !res_miss;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_cnt    <= '0;
      out_cnt   <= '0;
      rd_pend   <= 1'b0;
      flag      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      in_cnt  <= in_cnt_next;
      out_cnt <= out_cnt_next;
      rd_pend <= rd_pend_next;
      flag    <= flag_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    xfer_rd <= xfer_rd_next;
    xfer_wr <= xfer_wr_next;
    exp_val <= exp_next;
    if (res_load) begin
      out_status <= res_status;
      out_popped <= res_popped;
      out_miss   <= res_miss;
      out_all    <= flag_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(OUT_TDATA_W - DATA_W - 2){1'b0}}, out_all, out_miss, out_popped};

endmodule

>>> design/two_stack_fifo_queue_checker_core.sv
// Channel   Dir  tdata                                       tuser
// s_*       in   [31:0] value                                [0] mode
// m_*       out  [31:0] popped_value, [32] mismatch,         [1:0] status
//                [33] all_matched, [39:34] zero
//
// A push is written into the input stack and its result registered at the edge that
// accepts it. A pop from a non-empty output stack reads the stack memory when accepted and
// registers the read data as its result in ST_POP. A pop that finds the output stack empty
// first reads the n input-stack words, one per cycle, keeps n - 1 and returns the oldest.
// Reset clears the counts, the controller state and the sticky match flag, not the memories.
// A waiting result blocks the next beat, and no beat is taken during a pop or a transfer.
`include "assert_macros.svh"

module two_stack_fifo_queue_checker_core import tsq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [DATA_W-1:0]      s_tdata,  // [31:0] value
  input  logic [0:0]             s_tuser,  // [0] mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // [31:0] popped_value, [32] mismatch,
                                           // [33] all_matched, rest zero
  output logic [1:0]             m_tuser   // [1:0] status
);

  mem_req_t          in_req;
  mem_req_t          out_req;
  logic [DATA_W-1:0] in_rdata;
  logic [DATA_W-1:0] out_rdata;
  logic              push_result;

  // The controller owns the counts, the transfer sequence and the result register.
  tsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .in_req    (in_req),
    .in_rdata  (in_rdata),
    .out_req   (out_req),
    .out_rdata (out_rdata)
  );

  // Input stack: pushes write at the top, transfers read from the top down.
  tsq_ram #(
    .WIDTH     (DATA_W),
    .ADDR_BITS (ADDR_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (in_req.we),
    .waddr (in_req.waddr),
    .wdata (in_req.wdata),
    .re    (in_req.re),
    .raddr (in_req.raddr),
    .rdata (in_rdata)
  );

  // Output stack: transfers fill it from the bottom, pops read its top.
  tsq_ram #(
    .WIDTH     (DATA_W),
    .ADDR_BITS (ADDR_W)
  ) u_exit_ram (
    .clk   (clk),
    .we    (out_req.we),
    .waddr (out_req.waddr),
    .wdata (out_req.wdata),
    .re    (out_req.re),
    .raddr (out_req.raddr),
    .rdata (out_rdata)
  );

  // A result beat that answers a push, accepted or refused.
  assign push_result = m_tvalid && (m_tuser inside {STAT_PUSHED, STAT_FULL});

  // A waiting result must never be overwritten by a newly accepted beat.
  `ASSERT_IMPL(a_hold_blocks_input, clk, rst, m_tvalid && !m_tready, !s_tready)
  // Once the match flag has dropped it stays low in every later result.
  `ASSERT_NEXT(a_flag_sticky, clk, rst, m_tvalid && !m_tdata[DATA_W+1], !m_tdata[DATA_W+1])
  // Push results carry a zero value and never report a mismatch.
  `ASSERT_IMPL(a_push_clean, clk, rst, push_result, m_tdata[DATA_W:0] == '0)

endmodule

>>> sim/fifo_order_checker.sv
module fifo_order_checker import tsq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [DATA_W-1:0]      s_tdata,  // [31:0] value
  input  logic [0:0]             s_tuser,  // [0] mode
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,  // [31:0] popped_value, [32] mismatch,
                                           // [33] all_matched, rest zero
  input  logic [1:0]             m_tuser,  // [1:0] status
  output int                     failures,
  output int                     pending
);

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] popped;
    logic              mismatch;
    logic              all_matched;
  } queue_result_t;

  logic [DATA_W-1:0] entry_stack [DEPTH];
  logic [DATA_W-1:0] exit_stack  [DEPTH];
  int unsigned       in_count;
  int unsigned       out_count;
  logic              matched_so_far;
  queue_result_t     awaited_results[$];

  // Applies one beat to the two-stack model and returns the result it must produce.
  function automatic queue_result_t predict_queue_op(input logic mode,
                                                     input logic [DATA_W-1:0] val);
    queue_result_t r;
    r.status   = STAT_PUSHED;
    r.popped   = '0;
    r.mismatch = 1'b0;
    if (mode == MODE_PUSH) begin
      if (in_count + out_count >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        entry_stack[in_count] = val;
        in_count++;
      end
    end else begin
      if (out_count == 0) begin
        for (int i = 0; i < int'(in_count); i++)
          exit_stack[i] = entry_stack[in_count - 1 - i];
        out_count = in_count;
        in_count  = 0;
      end
      if (out_count == 0) begin
        r.status = STAT_EMPTY;
        r.popped = EMPTY_VALUE;
      end else begin
        out_count--;
        r.status = STAT_POPPED;
        r.popped = exit_stack[out_count];
      end
      if (r.popped != val) begin
        r.mismatch     = 1'b1;
        matched_so_far = 1'b0;
      end
    end
    r.all_matched = matched_so_far;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endfunction

  // A result taken at an edge always belongs to an earlier beat, so the
  // comparison runs before the beat accepted at the same edge is queued.
  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      in_count       = 0;
      out_count      = 0;
      matched_so_far = 1'b1;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual status %0h data %0h",
                   $time, m_tuser, m_tdata);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(m_tuser));
          check_field("popped_value", want.popped, m_tdata[DATA_W-1:0]);
          check_field("mismatch", DATA_W'(want.mismatch), DATA_W'(m_tdata[DATA_W]));
          check_field("all_matched", DATA_W'(want.all_matched), DATA_W'(m_tdata[DATA_W+1]));
          check_field("tdata padding", '0, DATA_W'(m_tdata[OUT_TDATA_W-1:DATA_W+2]));
        end
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(predict_queue_op(s_tuser[0], s_tdata));
    end
    pending = awaited_results.size();
  end

endmodule

>>> sim/tb.sv
module tb import tsq_pkg::*;;

  // A full transfer reads up to DEPTH words with no beat on either side, and the
  // one long receiver hold adds its own quiet stretch, so the limit covers both.
  localparam int WATCHDOG_CYCLES     = 5000;
  localparam int BACKPRESSURE_CYCLES = 400;
  localparam int BACKPRESSURE_AFTER  = 600;
  localparam int DRAIN_CYCLES        = 20;
  localparam int REFUSALS_WANTED     = 12;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata = '0;   // [31:0] value
  logic [0:0]             s_tuser = '0;   // [0] mode
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [31:0] popped_value, [32] mismatch,
                                          // [33] all_matched, rest zero
  logic [1:0]             m_tuser;        // [1:0] status

  int failures;
  int pending;
  int results_taken;
  int idle_cycles;

  // Contents the queue should hold, in order. The stimulus uses it to give most
  // pops the right expectation; the checking itself lives in the checker.
  logic [DATA_W-1:0] queue_shadow[$];
  int                pushes_refused;
  bit                send_steady;

  two_stack_fifo_queue_checker_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  fifo_order_checker order_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .failures(failures), .pending(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Mostly short gaps, now and then a long one; a steady stretch has none.
  function automatic int next_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random data with the extreme words mixed in.
  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return EMPTY_VALUE;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // What a pop should return right now.
  function automatic logic [DATA_W-1:0] front_value();
    return (queue_shadow.size() != 0) ? queue_shadow[0] : EMPTY_VALUE;
  endfunction

  // Offers one beat and returns at the edge where it is accepted. With no gap the
  // valid simply stays high, so it is never lowered and raised in one step.
  task automatic send_item(input logic mode, input logic [DATA_W-1:0] val);
    int gap;
    if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
    gap = next_gap(send_steady);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (mode == MODE_PUSH) begin
      if (queue_shadow.size() < DEPTH) queue_shadow.push_back(val);
      else pushes_refused++;
    end else if (queue_shadow.size() != 0) begin
      void'(queue_shadow.pop_front());
    end
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] corner_words[5];
    corner_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'h0000_0001};
    wait (!rst);

    // Directed opening. The first pop returns the oldest corner word and moves the other
    // four across, a push then lands while the output stack still holds data, and the
    // sixth pop of the run forces a transfer of a single word. The pop after that finds
    // the queue empty and expects the all-ones word, so the sticky flag stays up.
    foreach (corner_words[i]) send_item(MODE_PUSH, corner_words[i]);
    send_item(MODE_POP, front_value());
    send_item(MODE_PUSH, 32'h5555_5555);
    repeat (5) send_item(MODE_POP, front_value());
    send_item(MODE_POP, front_value());
    send_item(MODE_PUSH, 32'hAAAA_AAAA);
    send_item(MODE_POP, front_value());

    // Well-formed traffic with the flag still set: every pop expects the right word.
    repeat (150) begin
      if ($urandom_range(0, 99) < 55) send_item(MODE_PUSH, random_word());
      else send_item(MODE_POP, front_value());
    end
    while (queue_shadow.size() != 0) send_item(MODE_POP, front_value());

    // Mismatches: a wrong expectation on an empty pop drops the flag, a right one
    // afterwards must not raise it again, and a wrong one on real data follows.
    send_item(MODE_POP, 32'h0000_0000);
    send_item(MODE_POP, EMPTY_VALUE);
    send_item(MODE_PUSH, 32'h1234_5678);
    send_item(MODE_POP, 32'h8765_4321);

    // Push-heavy traffic until the queue is full and refuses pushes. Most pops are
    // correct, some carry random expectations. The long receiver hold lands here.
    while (pushes_refused < REFUSALS_WANTED) begin
      if ($urandom_range(0, 9) != 0) send_item(MODE_PUSH, random_word());
      else if ($urandom_range(0, 4) == 0) send_item(MODE_POP, random_word());
      else send_item(MODE_POP, front_value());
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: random ready gaps, plus one long hold once enough results have
  // gone by, so the output register stays full and the input stalls behind it.
  initial begin : result_sink
    int stall;
    bit steady;
    bit held;
    steady = 1'b0;
    held   = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 63) == 0) steady = !steady;
      if (!held && results_taken >= BACKPRESSURE_AFTER) begin
        held  = 1'b1;
        stall = BACKPRESSURE_CYCLES;
      end else begin
        stall = next_gap(steady);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: counts cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) results_taken <= results_taken + 1;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_CYCLES) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
